>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks used across the sine pipeline.
// Defining ASSERT_OFF removes every check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must hold in the cycle after a trigger, outside reset.
`define ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);
`else
`define ASSERT_SYNC(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, trig, cond, msg)
`endif

`endif

>>> sv/sfd_pkg.sv
// ----------------------------------------------------------------------------
// Sine pipeline package
// Widths, the per-term constant bundle and the item carried down the pipeline.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // Number of odd-power terms summed (first term included).
  localparam int TERM_COUNT = 17;

  localparam int ANGLE_W   = 16;
  localparam int OUT_W     = 18;
  localparam int FRAC_BITS = 24;

  // Q.24 magnitudes: angle in radians, its square, one series term.
  localparam int X_W    = 27;
  localparam int X2_W   = 30;
  localparam int TERM_W = 31;
  localparam int ACC_W  = 35;

  // Term divider: divisor (n-1)*n, and the split of the quotient into digits.
  localparam int DIV_W  = 11;
  localparam int PROD_W = TERM_W + X2_W;
  localparam int PQ_W   = PROD_W + 1 - FRAC_BITS;
  localparam int LO_W   = 18;
  localparam int HI_W   = PQ_W - LO_W;
  localparam int LO_N   = DIV_W + LO_W;
  localparam int MHI_W  = HI_W + 2;
  localparam int MLO_W  = LO_N + 2;
  localparam int SH_W   = 6;

  typedef struct packed {
    logic [DIV_W-1:0] div_c;
    logic [MHI_W-1:0] magic_hi;
    logic [MLO_W-1:0] magic_lo;
    logic [SH_W-1:0]  shift_hi;
    logic [SH_W-1:0]  shift_lo;
    logic             subtract;
  } term_const_t;

  typedef struct packed {
    logic                    neg;
    logic [X2_W-1:0]         x2;
    logic [TERM_W-1:0]       term;
    logic signed [ACC_W-1:0] acc;
  } series_item_t;

endpackage

>>> sv/sine_from_degrees_series.sv
// ----------------------------------------------------------------------------
// Sine from degrees by Taylor series
// Pipelined sine of an angle in 1/64 degree, returned as saturated Q1.16.
// ----------------------------------------------------------------------------
// The block takes one angle on every clock cycle while busy is low and
// returns its sine through a pipeline that never stalls. It is made of the
// front end (clamping, conversion to radians by a reciprocal multiply with a
// correction step, and squaring), six registers for every series term after
// the first (one product, rounding, two digits of division by a constant,
// each taken by a reciprocal multiply, and the running sum), with seventeen
// terms built in, and two registers for rounding, saturation and sign. A
// transfer in is taken at any rising edge with start high and busy low; busy
// is high only while rst is held and for the cycle after it. Each result is
// shown on sine_value for exactly one cycle with done high, in the order the
// angles came in; the receiver has no way to hold it back, so it must
// capture every result on the cycle that done is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sine_from_degrees_series (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [sfd_pkg::ANGLE_W-1:0] angle_deg,
  output logic                               done,
  output logic signed [sfd_pkg::OUT_W-1:0]   sine_value
);
  import sfd_pkg::*;

  // Valid bit and payload between consecutive parts of the pipeline. Entry 0
  // is the front end's output; entry k-1 is the sum after the k-th term.
  logic [TERM_COUNT-1:0] chain_valid;
  series_item_t          chain_item [TERM_COUNT];
  logic                  accept;

  // The pipeline never stalls, so busy only covers reset and the cycle after.
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept = start & ~busy;

  // The front end clamps the angle to one turn, converts it to Q.24 radians
  // and squares it; the first series term is the angle itself.
  sfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .angle_deg (angle_deg),
    .out_valid (chain_valid[0]),
    .out_item  (chain_item[0])
  );

  // One stage per further term. Term k uses power n = 2k-1 and divides the
  // previous term times x^2 by (n-1)*n. The division is done as a high digit
  // and a low digit, each by an exact reciprocal multiply whose constants are
  // worked out here at elaboration. Terms alternate in sign, starting with a
  // subtraction for the cube.
  for (genvar k = 2; k <= TERM_COUNT; k++) begin : g_term
    localparam int unsigned N = 2 * k - 1;
    localparam int unsigned C = (N - 1) * N;
    localparam int unsigned L = $clog2(C);
    localparam logic [63:0] M_HI = ((64'd1 << (HI_W + L)) + 64'(C) - 64'd1) / C;
    localparam logic [63:0] M_LO = ((64'd1 << (LO_N + L)) + 64'(C) - 64'd1) / C;
    localparam term_const_t TC = '{
      div_c:    DIV_W'(C),
      magic_hi: M_HI[MHI_W-1:0],
      magic_lo: M_LO[MLO_W-1:0],
      shift_hi: SH_W'(HI_W + L),
      shift_lo: SH_W'(LO_N + L),
      subtract: ((k % 2) == 0)
    };

    sfd_term u_term (
      .clk       (clk),
      .rst       (rst),
      .tc        (TC),
      .in_valid  (chain_valid[k-2]),
      .in_item   (chain_item[k-2]),
      .out_valid (chain_valid[k-1]),
      .out_item  (chain_item[k-1])
    );
  end

  // Rounding to Q1.16, saturation to plus or minus one and the angle's sign.
  sfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (chain_valid[TERM_COUNT-1]),
    .in_item    (chain_item[TERM_COUNT-1]),
    .done       (done),
    .sine_value (sine_value)
  );

  // Coming out of reset the whole pipeline has been flushed, so no result
  // may appear straight after busy.
  `ASSERT_NEXT(a_quiet_after_reset, clk, rst, busy, !done, "result right after reset")

endmodule

>>> sv/sfd_front.sv
// ----------------------------------------------------------------------------
// Sine pipeline front end
// Clamps the angle magnitude, converts degrees to Q.24 radians and squares it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfd_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic signed [sfd_pkg::ANGLE_W-1:0]  angle_deg,
  output logic                                out_valid,
  output sfd_pkg::series_item_t               out_item
);
  import sfd_pkg::*;

  localparam int A_W     = 15;
  localparam int Y_W     = 33;
  localparam int T_SHIFT = 13;
  localparam int T_W     = Y_W - T_SHIFT;
  localparam int R_SHIFT = 24;
  localparam int RCP_W   = 18;
  localparam int QP_W    = T_W + RCP_W;
  localparam int QE_W    = QP_W - R_SHIFT;
  localparam int DEN_W   = 20;
  localparam int XX_W    = 2 * X_W;

  localparam logic [A_W-1:0]   ANGLE_LIMIT = 15'd23040;
  // x = 4575*a + floor((193333*a + 351562) / 703125) is the rounded conversion.
  localparam logic [12:0]      DEG_INT     = 13'd4575;
  localparam logic [17:0]      DEG_FRAC    = 18'd193333;
  localparam logic [Y_W-1:0]   DEG_BIAS    = 33'd351562;
  localparam logic [DEN_W-1:0] DEG_DEN     = 20'd703125;
  localparam logic [63:0]      RCP_FULL    = (64'd1 << (T_SHIFT + R_SHIFT)) / DEG_DEN;
  localparam logic [RCP_W-1:0] DEN_RECIP   = RCP_FULL[RCP_W-1:0];
  localparam logic [X_W-1:0]   X_MAX       = 27'd105414335;
  localparam logic [XX_W:0]    SQ_HALF     = (XX_W+1)'(1) << (FRAC_BITS - 1);

  logic [ANGLE_W-1:0] angle_bits;
  logic [A_W+1:0]     mag_in;
  logic [A_W-1:0]     a_sat;

  logic               v0, v1, v2, v3, v4, v5;
  logic               neg0, neg1, neg2, neg3, neg4, neg5;
  logic [A_W-1:0]     a0;
  logic [X_W-1:0]     ax1, ax2, ax3;
  logic [Y_W-1:0]     y1, y2;
  logic [QP_W-1:0]    qp2;
  logic [QE_W-1:0]    q_est;
  logic [Y_W-1:0]     rem;
  logic [QE_W-1:0]    q3;
  logic [X_W-1:0]     x4, x5;
  logic [XX_W-1:0]    xx5;
  logic [XX_W:0]      xr;

  // Magnitude of the angle, clamped to one full turn.
  always_comb begin
    angle_bits = angle_deg;
    if (angle_bits[ANGLE_W-1]) begin
      mag_in = 17'h10000 - {1'b0, angle_bits};
    end else begin
      mag_in = {1'b0, angle_bits};
    end
    if (mag_in > {2'b00, ANGLE_LIMIT}) begin
      a_sat = ANGLE_LIMIT;
    end else begin
      a_sat = mag_in[A_W-1:0];
    end
  end

  // Quotient estimate is at most one low; the remainder test corrects it.
  always_comb begin
    q_est = qp2[QP_W-1:R_SHIFT];
    rem   = y2 - ({{(Y_W-QE_W){1'b0}}, q_est} * {{(Y_W-DEN_W){1'b0}}, DEG_DEN});
  end

  assign xr = {1'b0, xx5} + SQ_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v0 <= accept;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    neg0 <= angle_bits[ANGLE_W-1];
    a0   <= a_sat;

    neg1 <= neg0;
    ax1  <= {{(X_W-A_W){1'b0}}, a0} * {{(X_W-13){1'b0}}, DEG_INT};
    y1   <= ({{(Y_W-A_W){1'b0}}, a0} * {{(Y_W-18){1'b0}}, DEG_FRAC}) + DEG_BIAS;

    neg2 <= neg1;
    ax2  <= ax1;
    y2   <= y1;
    qp2  <= {{(QP_W-T_W){1'b0}}, y1[Y_W-1:T_SHIFT]} * {{(QP_W-RCP_W){1'b0}}, DEN_RECIP};

    neg3 <= neg2;
    ax3  <= ax2;
    if (rem >= {{(Y_W-DEN_W){1'b0}}, DEG_DEN}) begin
      q3 <= q_est + QE_W'(1);
    end else begin
      q3 <= q_est;
    end

    neg4 <= neg3;
    x4   <= ax3 + {{(X_W-QE_W){1'b0}}, q3};

    neg5 <= neg4;
    x5   <= x4;
    xx5  <= {{X_W{1'b0}}, x4} * {{X_W{1'b0}}, x4};

    out_item.neg  <= neg5;
    out_item.x2   <= xr[FRAC_BITS +: X2_W];
    out_item.term <= {{(TERM_W-X_W){1'b0}}, x5};
    out_item.acc  <= $signed({{(ACC_W-X_W){1'b0}}, x5});
  end

  `ASSERT_NEXT(a_radians_range, clk, rst, v3, x4 <= X_MAX, "angle in radians beyond one turn")

endmodule

>>> sv/sfd_term.sv
// ----------------------------------------------------------------------------
// Sine pipeline term stage
// Forms the next series term t*x^2/((n-1)*n) in Q.24 and adds it to the sum.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfd_term (
  input  logic                  clk,
  input  logic                  rst,
  input  sfd_pkg::term_const_t  tc,
  input  logic                  in_valid,
  input  sfd_pkg::series_item_t in_item,
  output logic                  out_valid,
  output sfd_pkg::series_item_t out_item
);
  import sfd_pkg::*;

  localparam int HP_W = HI_W + MHI_W;
  localparam int LP_W = LO_N + MLO_W;
  localparam int RW_W = HI_W + DIV_W;

  logic               v1, v2, v3, v4, v5;
  series_item_t       it1, it2, it3, it4, it5;
  logic [PROD_W-1:0]  prod1;
  logic [PROD_W:0]    prod_rnd;
  logic [PQ_W-1:0]    pq2;
  logic [LO_W-1:0]    lo3, lo4;
  logic [HI_W-1:0]    hi3;
  logic [HP_W-1:0]    hp3, hq_shift;
  logic [HI_W-1:0]    q_hi;
  logic [RW_W-1:0]    r_wide;
  logic [DIV_W-1:0]   r4;
  logic [HI_W-1:0]    qh4, qh5;
  logic [LO_N-1:0]    y4;
  logic [LP_W-1:0]    lp5, lq_shift;
  logic [HI_W+LO_W-1:0] q_full;
  logic [ACC_W-1:0]   term_ext;
  logic signed [ACC_W-1:0] acc_next;

  // Round half up by adding half the divisor scaled to Q.24.
  assign prod_rnd = {1'b0, prod1}
                  + ({{(PROD_W+1-DIV_W){1'b0}}, tc.div_c} << (FRAC_BITS - 1));

  // The quotient is taken as a high and a low digit, each by a reciprocal multiply.
  always_comb begin
    hq_shift = hp3 >> tc.shift_hi;
    q_hi     = hq_shift[HI_W-1:0];
    r_wide   = {{DIV_W{1'b0}}, hi3}
             - ({{DIV_W{1'b0}}, q_hi} * {{HI_W{1'b0}}, tc.div_c});
    y4       = {r4, lo4};
    lq_shift = lp5 >> tc.shift_lo;
    q_full   = {qh5, lq_shift[LO_W-1:0]};
    term_ext = {{(ACC_W-TERM_W){1'b0}}, q_full[TERM_W-1:0]};
    if (tc.subtract) begin
      acc_next = it5.acc - $signed(term_ext);
    end else begin
      acc_next = it5.acc + $signed(term_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    it1   <= in_item;
    prod1 <= {{X2_W{1'b0}}, in_item.term} * {{TERM_W{1'b0}}, in_item.x2};

    it2 <= it1;
    pq2 <= prod_rnd[PROD_W:FRAC_BITS];

    it3 <= it2;
    lo3 <= pq2[LO_W-1:0];
    hi3 <= pq2[PQ_W-1:LO_W];
    hp3 <= {{MHI_W{1'b0}}, pq2[PQ_W-1:LO_W]} * {{HI_W{1'b0}}, tc.magic_hi};

    it4 <= it3;
    lo4 <= lo3;
    qh4 <= q_hi;
    r4  <= r_wide[DIV_W-1:0];

    it5 <= it4;
    qh5 <= qh4;
    lp5 <= {{MLO_W{1'b0}}, y4} * {{LO_N{1'b0}}, tc.magic_lo};

    out_item.neg  <= it5.neg;
    out_item.x2   <= it5.x2;
    out_item.term <= q_full[TERM_W-1:0];
    out_item.acc  <= acc_next;
  end

  `ASSERT_NEXT(a_rem_below_div, clk, rst, v3, r4 < tc.div_c, "high digit remainder not reduced")
  `ASSERT_NEXT(a_term_fits, clk, rst, v4, qh5[HI_W-1:TERM_W-LO_W] == '0, "series term overflows")

endmodule

>>> sv/sfd_back.sv
// ----------------------------------------------------------------------------
// Sine pipeline back end
// Rounds the Q.24 sum to Q1.16, saturates to one and applies the angle's sign.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfd_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  sfd_pkg::series_item_t              in_item,
  output logic                               done,
  output logic signed [sfd_pkg::OUT_W-1:0]   sine_value
);
  import sfd_pkg::*;

  localparam int OUT_SHIFT = FRAC_BITS - 16;
  localparam int SM_W      = ACC_W - OUT_SHIFT;
  localparam int MAG_W     = OUT_W - 1;
  localparam logic [MAG_W-1:0] ONE_Q16    = 17'h10000;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (OUT_SHIFT - 1);

  logic [ACC_W-1:0] acc_u;
  logic [ACC_W-1:0] mag;
  logic [ACC_W-1:0] rnd;
  logic [SM_W-1:0]  mag_q16;
  logic             v1;
  logic             flip1;
  logic [MAG_W-1:0] m1;

  // Sum is rounded half away from zero by working on its magnitude.
  always_comb begin
    acc_u = in_item.acc;
    if (acc_u[ACC_W-1]) begin
      mag = {ACC_W{1'b0}} - acc_u;
    end else begin
      mag = acc_u;
    end
    rnd     = mag + ROUND_HALF;
    mag_q16 = rnd[ACC_W-1:OUT_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= in_valid;
      done <= v1;
    end
  end

  always_ff @(posedge clk) begin
    flip1 <= acc_u[ACC_W-1] ^ in_item.neg;
    if (mag_q16 > {{(SM_W-MAG_W){1'b0}}, ONE_Q16}) begin
      m1 <= ONE_Q16;
    end else begin
      m1 <= mag_q16[MAG_W-1:0];
    end
    if (flip1) begin
      sine_value <= {OUT_W{1'b0}} - {1'b0, m1};
    end else begin
      sine_value <= {1'b0, m1};
    end
  end

  `ASSERT_NEXT(a_mag_saturated, clk, rst, in_valid, m1 <= ONE_Q16, "magnitude above one")

endmodule
